// ===== src/per_key_sliding_window_rate_limiter_macros.svh =====
// Assertion macros for the sliding window rate limiter.
// Clocked on clock, disabled during reset; no other dependencies.
`ifndef PER_KEY_SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
`define PER_KEY_SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
`ifndef SYNTHESIS
// combinational property checked every cycle
`define SWRL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define SWRL_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);
`else
`define SWRL_ASSERT(label, prop, msg)
`define SWRL_ASSERT_NEXT(label, trig, cons, msg)
`endif
`endif

// ===== src/swrl_pkg.sv =====
// Shared constants, codes and structs of the sliding window rate limiter.
// No dependencies.
package swrl_pkg;

   // sizing
   localparam int NUM_KEYS      = 16;
   localparam int HISTORY_DEPTH = 16;
   localparam int MEM_DEPTH     = NUM_KEYS * HISTORY_DEPTH;
   localparam int KEY_W         = $clog2(NUM_KEYS);
   localparam int PTR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
   localparam int ADDR_W        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // field widths
   localparam int TYPE_W  = 2;
   localparam int KEYF_W  = 4;
   localparam int TIME_W  = 32;
   localparam int LIMIT_W = 16;
   localparam int COUNT_W = 5;
   localparam int COUNT_MAX = 31;

   localparam logic [TIME_W-1:0] RESET_WINDOW = 32'd3600;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_RECORD = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_CHECK  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_COUNT  = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd3;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW  = 1'b1;

   // key table command
   typedef struct packed {
      logic             clear;
      logic             record;
      logic [KEY_W-1:0] key;
   } keytab_cmd_type;

   // timestamp memory access
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [TIME_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // one result word
   typedef struct packed {
      logic               valid;
      logic               limited;
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } result_type;

   // entry address of a key's slot
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [KEY_W-1:0] key,
                                                   input logic [PTR_W-1:0] slot);
      slot_addr = ADDR_W'(32'(key) * HISTORY_DEPTH + 32'(slot));
   endfunction

endpackage

// ===== src/per_key_sliding_window_rate_limiter.sv =====
// Sliding window rate limiter: a record or clear goes through the EXEC and DONE states, and its
// result is then registered onto rsp_tvalid; the next word is taken back in IDLE. A check or
// count walks the key's ring one entry a cycle through the single read port of the timestamp
// memory, so how long it takes to reach DONE depends on the fill count of the key.
// One word in flight; the next word is accepted while a result waits in the output register.
// Synchronous active-high reset clears fill counts, pointers, state and configuration registers, not the memory.
module per_key_sliding_window_rate_limiter (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [55:0]                    req_tdata,  // key_index, now_seconds, has_limit, trade_limit
   input  logic [swrl_pkg::TYPE_W-1:0]    req_tuser,  // req_type
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,  // rate_limited, window_count, history_overflow
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [swrl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);

   logic                        enabled_ff;
   logic [swrl_pkg::TIME_W-1:0] window_ff;

   swrl_pkg::keytab_cmd_type    kt_cmd;
   logic [swrl_pkg::FILL_W-1:0] kt_fill;
   logic [swrl_pkg::PTR_W-1:0]  kt_wptr;
   swrl_pkg::mem_req_type       mem_req;
   logic [swrl_pkg::TIME_W-1:0] mem_rd_data;
   swrl_pkg::result_type        result;
   logic                        result_ready;

   logic                        rsp_vld_ff;
   logic [7:0]                  rsp_data_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         window_ff  <= swrl_pkg::RESET_WINDOW;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            swrl_pkg::CSR_ENABLED: enabled_ff <= csr_wdata[0];
            swrl_pkg::CSR_WINDOW:  window_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   swrl_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_type       (req_tuser),
      .key_index      (req_tdata[3:0]),
      .now_seconds    (req_tdata[35:4]),
      .has_limit      (req_tdata[36]),
      .trade_limit    (req_tdata[52:37]),
      .enabled        (enabled_ff),
      .window_limit   (window_ff),
      .kt_cmd         (kt_cmd),
      .kt_fill        (kt_fill),
      .kt_wptr        (kt_wptr),
      .mem_req        (mem_req),
      .mem_rd_data    (mem_rd_data),
      .result         (result),
      .result_ready   (result_ready)
   );

   swrl_keytab u_keytab (
      .clock (clock),
      .reset (reset),
      .cmd   (kt_cmd),
      .fill  (kt_fill),
      .wptr  (kt_wptr)
   );

   swrl_tsram u_tsram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   // output register
   assign result_ready = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (result_ready) begin
         rsp_vld_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (result_ready && result.valid) begin
         rsp_data_ff <= {1'b0, result.overflow, result.count, result.limited};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/swrl_tsram.sv =====
// Timestamp store: one write port, one read port, registered read data.
// Depends on swrl_pkg for depth and widths.
module swrl_tsram (
   input  logic                        clock,
   input  swrl_pkg::mem_req_type       mem_req,
   output logic [swrl_pkg::TIME_W-1:0] rd_data
);

   logic [swrl_pkg::TIME_W-1:0] mem [swrl_pkg::MEM_DEPTH];
   logic [swrl_pkg::TIME_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/swrl_keytab.sv =====
// Per-key fill count and write pointer, held in flip-flops.
// Depends on swrl_pkg for sizes and the command struct.
module swrl_keytab (
   input  logic                        clock,
   input  logic                        reset,
   input  swrl_pkg::keytab_cmd_type    cmd,
   output logic [swrl_pkg::FILL_W-1:0] fill,
   output logic [swrl_pkg::PTR_W-1:0]  wptr
);

   logic [swrl_pkg::FILL_W-1:0] fill_ff [swrl_pkg::NUM_KEYS];
   logic [swrl_pkg::PTR_W-1:0]  wptr_ff [swrl_pkg::NUM_KEYS];
   logic [swrl_pkg::FILL_W-1:0] fill_in;
   logic [swrl_pkg::PTR_W-1:0]  wptr_in;

   assign fill = fill_ff[cmd.key];
   assign wptr = wptr_ff[cmd.key];

   // advance on a record: fill saturates at depth, pointer wraps
   always_comb begin
      fill_in = fill;
      if (32'(fill) < swrl_pkg::HISTORY_DEPTH) begin
         fill_in = fill + swrl_pkg::FILL_W'(1);
      end
      if (32'(wptr) == swrl_pkg::HISTORY_DEPTH - 1) begin
         wptr_in = '0;
      end else begin
         wptr_in = wptr + swrl_pkg::PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int k = 0; k < swrl_pkg::NUM_KEYS; k++) begin
            fill_ff[k] <= '0;
            wptr_ff[k] <= '0;
         end
      end else if (cmd.record) begin
         fill_ff[cmd.key] <= fill_in;
         wptr_ff[cmd.key] <= wptr_in;
      end
   end

endmodule

// ===== src/swrl_seq.sv =====
// Request sequencer: executes records and clears, scans a key's ring for checks and counts.
// Depends on swrl_pkg and the assertion macro header.
`include "per_key_sliding_window_rate_limiter_macros.svh"
module swrl_seq (
   input  logic                         clock,
   input  logic                         reset,
   // request word
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [swrl_pkg::TYPE_W-1:0]  req_type,
   input  logic [swrl_pkg::KEYF_W-1:0]  key_index,
   input  logic [swrl_pkg::TIME_W-1:0]  now_seconds,
   input  logic                         has_limit,
   input  logic [swrl_pkg::LIMIT_W-1:0] trade_limit,
   // configuration
   input  logic                         enabled,
   input  logic [swrl_pkg::TIME_W-1:0]  window_limit,
   // key table
   output swrl_pkg::keytab_cmd_type     kt_cmd,
   input  logic [swrl_pkg::FILL_W-1:0]  kt_fill,
   input  logic [swrl_pkg::PTR_W-1:0]   kt_wptr,
   // timestamp memory
   output swrl_pkg::mem_req_type        mem_req,
   input  logic [swrl_pkg::TIME_W-1:0]  mem_rd_data,
   // result
   output swrl_pkg::result_type         result,
   input  logic                         result_ready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;

   // latched request
   logic [swrl_pkg::TYPE_W-1:0]  type_ff;
   logic [swrl_pkg::KEYF_W-1:0]  key_ff;
   logic [swrl_pkg::TIME_W-1:0]  now_ff;
   logic                         has_limit_ff;
   logic [swrl_pkg::LIMIT_W-1:0] limit_ff;

   // scan state
   logic [swrl_pkg::FILL_W-1:0]  idx_ff, idx_in;
   logic [swrl_pkg::FILL_W-1:0]  count_ff, count_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic                         ovf_ff, ovf_in;

   logic                         accept;
   logic                         key_ok;
   logic                         do_record;
   logic [swrl_pkg::FILL_W-1:0]  eff_fill;
   logic                         issue;
   logic                         hit;
   logic [swrl_pkg::TIME_W-1:0]  age;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign key_ok    = 32'(key_ff) < swrl_pkg::NUM_KEYS;
   assign eff_fill  = key_ok ? kt_fill : '0;
   assign do_record = (state_ff == ST_EXEC) && (type_ff == swrl_pkg::REQ_RECORD)
                      && enabled && key_ok;

   // key table commands
   assign kt_cmd.key    = swrl_pkg::KEY_W'(key_ff);
   assign kt_cmd.record = do_record;
   assign kt_cmd.clear  = (state_ff == ST_EXEC) && (type_ff == swrl_pkg::REQ_CLEAR);

   // scan: one read issued a cycle, compared as it returns
   assign issue = (state_ff == ST_SCAN) && (idx_ff < eff_fill);
   assign age   = now_ff - mem_rd_data;
   assign hit   = rd_vld_ff && ((mem_rd_data >= now_ff) || (age <= window_limit));

   assign mem_req.wr_en   = do_record;
   assign mem_req.wr_addr = swrl_pkg::slot_addr(kt_cmd.key, kt_wptr);
   assign mem_req.wr_data = now_ff;
   assign mem_req.rd_en   = issue;
   assign mem_req.rd_addr = swrl_pkg::slot_addr(kt_cmd.key, idx_ff[swrl_pkg::PTR_W-1:0]);

   // sequencing
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      rd_vld_in = 1'b0;
      ovf_in    = ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            idx_in   = '0;
            count_in = '0;
            ovf_in   = do_record && (32'(kt_fill) >= swrl_pkg::HISTORY_DEPTH);
            if ((type_ff == swrl_pkg::REQ_CHECK) || (type_ff == swrl_pkg::REQ_COUNT)) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            rd_vld_in = issue;
            if (issue) begin
               idx_in = idx_ff + swrl_pkg::FILL_W'(1);
            end
            if (hit) begin
               count_in = count_ff + swrl_pkg::FILL_W'(1);
            end
            if (!issue && !rd_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (result_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
         ovf_ff    <= ovf_in;
      end
   end

   // request payload, held for the whole item
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff      <= req_type;
         key_ff       <= key_index;
         now_ff       <= now_seconds;
         has_limit_ff <= has_limit;
         limit_ff     <= trade_limit;
      end
   end

   // result word
   always_comb begin
      result.valid    = (state_ff == ST_DONE);
      result.overflow = ovf_ff;
      result.count    = (32'(count_ff) > swrl_pkg::COUNT_MAX) ?
                        swrl_pkg::COUNT_W'(swrl_pkg::COUNT_MAX) :
                        swrl_pkg::COUNT_W'(count_ff);
      result.limited  = (type_ff == swrl_pkg::REQ_CHECK) && enabled && has_limit_ff
                        && key_ok && (eff_fill != '0)
                        && (32'(count_ff) >= 32'(limit_ff));
   end

   // checks
   `SWRL_ASSERT_NEXT(a_accept_exec, accept, state_ff == ST_EXEC, "accepted word not executed")
   `SWRL_ASSERT_NEXT(a_read_returns, issue, rd_vld_ff && (state_ff == ST_SCAN), "read lost")
   `SWRL_ASSERT(a_count_le_idx, (state_ff != ST_SCAN) || (count_ff <= idx_ff), "count overran")
   `SWRL_ASSERT(a_no_write_in_scan, !(mem_req.wr_en && (state_ff != ST_EXEC)), "stray write")

endmodule

// ===== tb/per_key_sliding_window_rate_limiter_tb.sv =====
// Self-checking testbench for the per-key sliding window rate limiter.
// Drives request and register words, predicts every response and compares it field by field.
// Depends on swrl_pkg and per_key_sliding_window_rate_limiter only.
`timescale 1ns / 100ps

module per_key_sliding_window_rate_limiter_tb;

   localparam int DRAIN_CYCLES = 40;     // quiet time after the last response
   localparam int HOLD_CYCLES  = 200;    // long receiver hold-off
   localparam int PHASE_WORDS  = 75;

   typedef struct packed {
      logic [swrl_pkg::TYPE_W-1:0]  kind;
      logic [swrl_pkg::KEYF_W-1:0]  key;
      logic [swrl_pkg::TIME_W-1:0]  now;
      logic                         has_limit;
      logic [swrl_pkg::LIMIT_W-1:0] limit;
   } limiter_req_type;

   // laid out as on rsp_tdata, highest field first
   typedef struct packed {
      logic                         overflow;
      logic [swrl_pkg::COUNT_W-1:0] count;
      logic                         limited;
   } limiter_rsp_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [55:0]                    req_tdata  = '0;  // key_index, now_seconds, has_limit, trade_limit
   logic [swrl_pkg::TYPE_W-1:0]    req_tuser  = '0;  // req_type
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [7:0]                     rsp_tdata;        // rate_limited, window_count, history_overflow
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [swrl_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [31:0]                    csr_wdata  = '0;

   per_key_sliding_window_rate_limiter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: one timestamp ring per key plus the two registers
   logic [swrl_pkg::TIME_W-1:0] ts_log [swrl_pkg::NUM_KEYS][swrl_pkg::HISTORY_DEPTH];
   int                          ring_fill [swrl_pkg::NUM_KEYS];
   logic [swrl_pkg::PTR_W-1:0]  ring_wptr [swrl_pkg::NUM_KEYS];
   logic                        limiter_on;
   logic [swrl_pkg::TIME_W-1:0] window_len;

   limiter_rsp_type pending_results [$];
   int              errors = 0;

   // stimulus shaping
   logic [swrl_pkg::TIME_W-1:0] cur_time;
   logic [swrl_pkg::TIME_W-1:0] step_max;
   bit                          tx_no_gaps   = 1'b0;
   bit                          rx_no_stalls = 1'b0;
   int                          hold_requests = 0;
   int                          hold_seen     = 0;
   int                          hold_left     = 0;
   int                          stall_left    = 0;

   task automatic reset_model();
      for (int k = 0; k < swrl_pkg::NUM_KEYS; k++) begin
         ring_fill[k] = 0;
         ring_wptr[k] = '0;
         for (int i = 0; i < swrl_pkg::HISTORY_DEPTH; i++) ts_log[k][i] = '0;
      end
      limiter_on = 1'b0;
      window_len = swrl_pkg::RESET_WINDOW;
   endtask

   // expected response of one request; updates the rings
   function automatic limiter_rsp_type predict_response(input limiter_req_type rq);
      limiter_rsp_type             rs;
      int                          n;
      logic [swrl_pkg::TIME_W-1:0] age;
      logic [swrl_pkg::PTR_W-1:0]  wp;
      rs = '0;
      n  = 0;
      case (rq.kind) inside
         swrl_pkg::REQ_RECORD: begin
            if (limiter_on) begin
               wp = ring_wptr[rq.key];
               if (ring_fill[rq.key] >= swrl_pkg::HISTORY_DEPTH) rs.overflow = 1'b1;
               else ring_fill[rq.key]++;
               ts_log[rq.key][wp] = rq.now;
               ring_wptr[rq.key] = swrl_pkg::PTR_W'((int'(wp) + 1) % swrl_pkg::HISTORY_DEPTH);
            end
         end
         swrl_pkg::REQ_CHECK, swrl_pkg::REQ_COUNT: begin
            for (int i = 0; i < ring_fill[rq.key]; i++) begin
               age = rq.now - ts_log[rq.key][i];
               // stamps from the future count as inside
               if (ts_log[rq.key][i] >= rq.now || age <= window_len) n++;
            end
            rs.count = swrl_pkg::COUNT_W'((n > swrl_pkg::COUNT_MAX) ? swrl_pkg::COUNT_MAX : n);
            if (rq.kind == swrl_pkg::REQ_CHECK && limiter_on && rq.has_limit
                && ring_fill[rq.key] != 0)
               rs.limited = (n >= int'(rq.limit));
         end
         default: begin
            for (int k = 0; k < swrl_pkg::NUM_KEYS; k++) begin
               ring_fill[k] = 0;
               ring_wptr[k] = '0;
            end
         end
      endcase
      return rs;
   endfunction

   function automatic limiter_req_type mk_req(input logic [swrl_pkg::TYPE_W-1:0] kind,
                                              input logic [swrl_pkg::KEYF_W-1:0] key,
                                              input logic [swrl_pkg::TIME_W-1:0] now,
                                              input logic has_limit,
                                              input logic [swrl_pkg::LIMIT_W-1:0] limit);
      limiter_req_type rq;
      rq.kind      = kind;
      rq.key       = key;
      rq.now       = now;
      rq.has_limit = has_limit;
      rq.limit     = limit;
      return rq;
   endfunction

   // mostly nondecreasing time on a few keys, with some noise words
   function automatic limiter_req_type random_request();
      limiter_req_type rq;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)      rq.kind = swrl_pkg::REQ_RECORD;
      else if (pick < 70) rq.kind = swrl_pkg::REQ_CHECK;
      else if (pick < 96) rq.kind = swrl_pkg::REQ_COUNT;
      else                rq.kind = swrl_pkg::REQ_CLEAR;
      rq.key = ($urandom_range(0, 3) != 0) ?
               swrl_pkg::KEYF_W'($urandom_range(0, 3)) :
               swrl_pkg::KEYF_W'($urandom_range(0, swrl_pkg::NUM_KEYS - 1));
      if ($urandom_range(0, 19) == 0) begin
         rq.now = $urandom;
      end else begin
         cur_time = cur_time + $urandom_range(0, step_max);
         rq.now   = cur_time;
      end
      rq.has_limit = ($urandom_range(0, 4) != 0);
      rq.limit = ($urandom_range(0, 9) == 0) ?
                 swrl_pkg::LIMIT_W'($urandom) :
                 swrl_pkg::LIMIT_W'($urandom_range(0, swrl_pkg::HISTORY_DEPTH + 1));
      return rq;
   endfunction

   // one request word; valid stays high when the next word follows at once
   task automatic offer_request(input limiter_req_type rq);
      int gap;
      gap = tx_no_gaps ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.kind;
      req_tdata  <= {3'b000, rq.limit, rq.has_limit, rq.now, rq.key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.insert(pending_results.size(), predict_response(rq));
   endtask

   // drop valid and wait until every response is back and the block is quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [swrl_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [31:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == swrl_pkg::CSR_ENABLED) limiter_on = value[0];
      else window_len = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // disabled block, reset window, window edges, future stamps, no limit, clear
   task automatic test_directed();
      offer_request(mk_req(swrl_pkg::REQ_RECORD, 4'd0, 32'd100, 1'b1, 16'd0));
      offer_request(mk_req(swrl_pkg::REQ_CHECK,  4'd0, 32'd100, 1'b1, 16'd0));
      offer_request(mk_req(swrl_pkg::REQ_COUNT,  4'd0, 32'd100, 1'b0, 16'd0));
      write_register(swrl_pkg::CSR_ENABLED, 32'd1);
      // window still at its reset value here
      offer_request(mk_req(swrl_pkg::REQ_CHECK,  4'd1, 32'd0,    1'b1, 16'd0));
      offer_request(mk_req(swrl_pkg::REQ_RECORD, 4'd0, 32'd1000, 1'b1, 16'd3));
      offer_request(mk_req(swrl_pkg::REQ_RECORD, 4'd0, 32'd4600, 1'b0, 16'd0));
      offer_request(mk_req(swrl_pkg::REQ_COUNT,  4'd0, 32'd4600, 1'b1, 16'd0));
      offer_request(mk_req(swrl_pkg::REQ_COUNT,  4'd0, 32'd4601, 1'b1, 16'd0));
      offer_request(mk_req(swrl_pkg::REQ_CHECK,  4'd0, 32'd4601, 1'b1, 16'd1));
      offer_request(mk_req(swrl_pkg::REQ_CHECK,  4'd0, 32'd4601, 1'b0, 16'd0));
      offer_request(mk_req(swrl_pkg::REQ_CHECK,  4'd0, 32'd4601, 1'b1, 16'd2));
      offer_request(mk_req(swrl_pkg::REQ_COUNT,  4'd0, 32'd500,  1'b1, 16'd0));
      offer_request(mk_req(swrl_pkg::REQ_RECORD, 4'd15, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
      offer_request(mk_req(swrl_pkg::REQ_CHECK,  4'd15, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
      offer_request(mk_req(swrl_pkg::REQ_CHECK,  4'd15, 32'hFFFF_FFFF, 1'b1, 16'd0));
      offer_request(mk_req(swrl_pkg::REQ_COUNT,  4'd15, 32'd0, 1'b1, 16'd0));
      // disabled: counts act, checks report no limit and records are not stored
      write_register(swrl_pkg::CSR_ENABLED, 32'd0);
      offer_request(mk_req(swrl_pkg::REQ_COUNT,  4'd0, 32'd4601, 1'b1, 16'd1));
      offer_request(mk_req(swrl_pkg::REQ_CHECK,  4'd0, 32'd4601, 1'b1, 16'd1));
      offer_request(mk_req(swrl_pkg::REQ_RECORD, 4'd0, 32'd4601, 1'b1, 16'd1));
      write_register(swrl_pkg::CSR_ENABLED, 32'd1);
      write_register(swrl_pkg::CSR_WINDOW, 32'd0);
      offer_request(mk_req(swrl_pkg::REQ_COUNT,  4'd0, 32'd4600, 1'b1, 16'd0));
      offer_request(mk_req(swrl_pkg::REQ_CLEAR,  4'd7, 32'd4600, 1'b1, 16'd9));
      offer_request(mk_req(swrl_pkg::REQ_COUNT,  4'd0, 32'd4600, 1'b1, 16'd0));
      offer_request(mk_req(swrl_pkg::REQ_CHECK,  4'd0, 32'd4600, 1'b1, 16'd0));
   endtask

   // fill one ring past its depth so the oldest stamps get overwritten
   task automatic test_ring_wrap();
      write_register(swrl_pkg::CSR_WINDOW, 32'hFFFF_FFFF);
      cur_time = $urandom;
      step_max = 32'd1000;
      for (int i = 0; i < swrl_pkg::HISTORY_DEPTH + 4; i++) begin
         cur_time = cur_time + $urandom_range(1, 1000);
         offer_request(mk_req(swrl_pkg::REQ_RECORD, 4'd3, cur_time, 1'b1,
                              swrl_pkg::LIMIT_W'($urandom)));
         if (i == swrl_pkg::HISTORY_DEPTH - 1)
            offer_request(mk_req(swrl_pkg::REQ_COUNT, 4'd3, cur_time, 1'b1, 16'd0));
      end
      offer_request(mk_req(swrl_pkg::REQ_CHECK, 4'd3, cur_time, 1'b1,
                           swrl_pkg::LIMIT_W'(swrl_pkg::HISTORY_DEPTH)));
      offer_request(mk_req(swrl_pkg::REQ_CHECK, 4'd3, cur_time, 1'b1,
                           swrl_pkg::LIMIT_W'(swrl_pkg::HISTORY_DEPTH + 1)));
      offer_request(mk_req(swrl_pkg::REQ_COUNT, 4'd3, 32'd0, 1'b0, 16'd0));
   endtask

   // long receiver hold-off with the sender pushing, then a full pause and a second hold-off
   task automatic test_backpressure();
      write_register(swrl_pkg::CSR_WINDOW, 32'd50);
      cur_time = $urandom;
      step_max = 32'd8;
      hold_requests <= hold_requests + 1;
      tx_no_gaps = 1'b1;
      repeat (24) offer_request(random_request());
      tx_no_gaps = 1'b0;
      settle();
      repeat (12) offer_request(random_request());
      hold_requests <= hold_requests + 1;
      repeat (12) offer_request(random_request());
   endtask

   // random words over several register settings, extremes included
   task automatic test_random_phases();
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               write_register(swrl_pkg::CSR_WINDOW, 32'd0);
               step_max = 32'd2;
            end
            1: begin
               write_register(swrl_pkg::CSR_WINDOW, 32'hFFFF_FFFF);
               step_max = 32'hFFFF;
            end
            2: begin
               write_register(swrl_pkg::CSR_WINDOW, swrl_pkg::RESET_WINDOW);
               step_max = 32'd600;
            end
            3: begin
               write_register(swrl_pkg::CSR_ENABLED, 32'd0);
               write_register(swrl_pkg::CSR_WINDOW, $urandom_range(1, 40));
               step_max = 32'd10;
            end
            4: begin
               write_register(swrl_pkg::CSR_ENABLED, 32'd1);
               write_register(swrl_pkg::CSR_WINDOW, $urandom_range(1, 40));
               step_max = 32'd10;
            end
            default: begin
               write_register(swrl_pkg::CSR_WINDOW, $urandom);
               step_max = 32'hFFFF_FFFF;
            end
         endcase
         cur_time = $urandom;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            // a stretch with no idling on either side
            if (i == 20) begin
               tx_no_gaps   = 1'b1;
               rx_no_stalls <= 1'b1;
            end else if (i == 36) begin
               tx_no_gaps   = 1'b0;
               rx_no_stalls <= 1'b0;
            end
            offer_request(random_request());
         end
      end
   endtask

   // response side: checks each word, then decides its own stalls
   always @(posedge clock) begin
      limiter_rsp_type got;
      limiter_rsp_type want;
      int              stall;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = limiter_rsp_type'(rsp_tdata[6:0]);
            if (pending_results.size() == 0) begin
               $display("%0t: response word expected none actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (got.limited !== want.limited) begin
                  $display("%0t: rate_limited expected %0d actual %0d",
                           $time, want.limited, got.limited);
                  errors++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: window_count expected %0d actual %0d",
                           $time, want.count, got.count);
                  errors++;
               end
               if (got.overflow !== want.overflow) begin
                  $display("%0t: history_overflow expected %0d actual %0d",
                           $time, want.overflow, got.overflow);
                  errors++;
               end
            end
         end
         if (hold_requests != hold_seen) begin
            hold_seen  <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            stall = rx_no_stalls ? 0 : $urandom_range(0, 5);
            stall_left <= (stall > 0) ? stall - 1 : 0;
            rsp_tready <= (stall == 0);
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      reset_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_ring_wrap();
      test_backpressure();
      test_random_phases();
      settle();
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
